// File: rtl/vlsf_pkg.sv
// Shared constants, types and tables of the vertical line segment filter.
package vlsf_pkg;

  // Store size and derived counter width.
  localparam int MAX_LINES = 64;
  localparam int CNT_W     = $clog2(MAX_LINES + 1);

  // Field widths.
  localparam int COORD_W = 12;
  localparam int ANG_W   = 15;
  localparam int ICP_W   = 17;
  localparam int MAG_W   = 17;
  localparam int WID_W   = 13;
  localparam int ATH_W   = 15;
  localparam int ITH_W   = 16;
  localparam int CFG_W   = 16;
  localparam int ADDR_W  = 2;

  // Register indexes of the configuration port.
  localparam logic [ADDR_W-1:0] REG_IMAGE_WIDTH = 2'd0;
  localparam logic [ADDR_W-1:0] REG_ANGLE_THR   = 2'd1;
  localparam logic [ADDR_W-1:0] REG_ICP_THR     = 2'd2;

  // Angle constants in 1/256 degree.
  localparam logic [ANG_W-1:0] ANGLE_90 = 15'd23040;
  localparam logic [ANG_W-1:0] ANGLE_LO = 15'd20480;
  localparam logic [COORD_W+1:0] BORDER = 14'd10;

  // Saturation bounds of the intercept.
  localparam logic signed [31:0] SAT_HI = 32'sd65535;
  localparam logic signed [31:0] SAT_LO = -32'sd65536;

  // Iteration counts of the arithmetic units.
  localparam int CORDIC_STEPS = 18;
  localparam int STEP_W       = 5;
  localparam int DIVIDEND_W   = 30;
  localparam int DIVISOR_W    = 13;
  localparam int DIV_CNT_W    = 5;
  localparam int Z_W          = 26;
  localparam int XY_W         = 32;

  // Reset values of the registers.
  localparam logic [WID_W-1:0] WIDTH_RST = 13'd640;
  localparam logic [ATH_W-1:0] ATH_RST   = 15'd512;
  localparam logic [ITH_W-1:0] ITH_RST   = 16'd48;

  // Candidate that walks along the cell row.
  typedef struct packed {
    logic             valid;
    logic [CNT_W-1:0] rem;
    logic             dup;
    logic [ANG_W-1:0] angle;
    logic [MAG_W-1:0] mag;
  } tok_t;

  // One stored line.
  typedef struct packed {
    logic [ANG_W-1:0] angle;
    logic [MAG_W-1:0] mag;
  } ent_t;

  // Duplicate thresholds broadcast to every cell.
  typedef struct packed {
    logic [ATH_W-1:0] ang_thr;
    logic [ITH_W-1:0] icp_thr;
  } thr_t;

  // Arctangent of 2^-i in 1/65536 degree.
  function automatic logic [Z_W-1:0] atan_entry(input logic [STEP_W-1:0] idx);
    logic [Z_W-1:0] v;
    case (idx)
      5'd0:  v = 26'd2949120;
      5'd1:  v = 26'd1740967;
      5'd2:  v = 26'd919879;
      5'd3:  v = 26'd466945;
      5'd4:  v = 26'd234379;
      5'd5:  v = 26'd117304;
      5'd6:  v = 26'd58666;
      5'd7:  v = 26'd29335;
      5'd8:  v = 26'd14668;
      5'd9:  v = 26'd7334;
      5'd10: v = 26'd3667;
      5'd11: v = 26'd1833;
      5'd12: v = 26'd917;
      5'd13: v = 26'd458;
      5'd14: v = 26'd229;
      5'd15: v = 26'd115;
      5'd16: v = 26'd57;
      5'd17: v = 26'd29;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/vlsf_cordic.sv
// Iterative CORDIC vectoring unit, one micro-rotation per cycle.
module vlsf_cordic import vlsf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [COORD_W-1:0] adx,
  input  logic [COORD_W-1:0] ady,
  output logic [ANG_W-1:0]   angle
);

  logic signed [XY_W-1:0] x;
  logic signed [XY_W-1:0] y;
  logic signed [Z_W-1:0]  z;
  logic [STEP_W-1:0]      step;
  logic                   run;
  logic signed [XY_W-1:0] xs;
  logic signed [XY_W-1:0] ys;
  logic signed [XY_W-1:0] yneg;
  logic signed [Z_W-1:0]  tab;
  logic [Z_W-1:0]         zr;

  // Shifts truncate toward zero; x stays positive throughout.
  always_comb begin
    yneg = -y;
    xs   = x >>> step;
    ys   = y[XY_W-1] ? -(yneg >>> step) : (y >>> step);
    tab  = signed'(atan_entry(step));
  end

  // One rotation per cycle until all steps are done.
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      step <= '0;
    end else if (start) begin
      x    <= signed'({4'd0, adx, 16'd0});
      y    <= signed'({4'd0, ady, 16'd0});
      z    <= '0;
      step <= '0;
      run  <= 1'b1;
    end else if (run) begin
      if (!y[XY_W-1]) begin
        x <= x + ys;
        y <= y - xs;
        z <= z + tab;
      end else begin
        x <= x - ys;
        y <= y + xs;
        z <= z - tab;
      end
      step <= step + 1'b1;
      if (step == STEP_W'(CORDIC_STEPS - 1)) begin
        run <= 1'b0;
      end
    end
  end

  // Round to 1/256 degree and clamp.
  always_comb begin
    zr = Z_W'(z + Z_W'(128)) >> 8;
    if (z[Z_W-1]) begin
      angle = '0;
    end else if (zr > Z_W'(ANGLE_90)) begin
      angle = ANGLE_90;
    end else begin
      angle = zr[ANG_W-1:0];
    end
  end

endmodule

// File: rtl/vlsf_div.sv
// Restoring divider, one quotient bit per cycle.
module vlsf_div import vlsf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic [DIVIDEND_W-1:0] quotient
);

  logic [DIVIDEND_W-1:0] num;
  logic [DIVISOR_W-1:0]  den;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIV_CNT_W-1:0]  cnt;
  logic                  run;
  logic [DIVISOR_W:0]    trial;

  assign trial = {rem, num[DIVIDEND_W-1]};

  // Shift in one dividend bit, subtract when the trial fits.
  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      num      <= dividend;
      den      <= divisor;
      rem      <= '0;
      quotient <= '0;
      cnt      <= '0;
      run      <= 1'b1;
    end else if (run) begin
      num <= num << 1;
      if (trial >= {1'b0, den}) begin
        rem      <= DIVISOR_W'(trial - {1'b0, den});
        quotient <= {quotient[DIVIDEND_W-2:0], 1'b1};
      end else begin
        rem      <= trial[DIVISOR_W-1:0];
        quotient <= {quotient[DIVIDEND_W-2:0], 1'b0};
      end
      cnt <= cnt + 1'b1;
      if (cnt == DIV_CNT_W'(DIVIDEND_W - 1)) begin
        run <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/vlsf_cell.sv
// One store cell: holds a line, checks the passing candidate against it.
module vlsf_cell import vlsf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  thr_t thr,
  input  tok_t tok_in,
  output tok_t tok_out,
  input  logic shift_en,
  input  ent_t ent_in,
  output ent_t ent
);

  logic signed [ANG_W:0] da;
  logic signed [MAG_W:0] di;
  logic [ANG_W:0]        da_abs;
  logic [MAG_W:0]        di_abs;
  logic                  match;

  // Duplicate test against the held line.
  always_comb begin
    da     = signed'({1'b0, tok_in.angle}) - signed'({1'b0, ent.angle});
    di     = signed'({1'b0, tok_in.mag}) - signed'({1'b0, ent.mag});
    da_abs = da[ANG_W] ? unsigned'(-da) : unsigned'(da);
    di_abs = di[MAG_W] ? unsigned'(-di) : unsigned'(di);
    match  = (tok_in.rem != '0) && (da_abs < {1'b0, thr.ang_thr}) &&
             (di_abs < {2'b0, thr.icp_thr});
  end

  // Hand the candidate on, one cell per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
    end
    tok_out.rem   <= (tok_in.rem == '0) ? '0 : tok_in.rem - 1'b1;
    tok_out.dup   <= tok_in.dup | match;
    tok_out.angle <= tok_in.angle;
    tok_out.mag   <= tok_in.mag;
  end

  // Stored lines move one cell along when a new one enters.
  always_ff @(posedge clk) begin
    if (shift_en) begin
      ent <= ent_in;
    end
  end

endmodule

// File: rtl/vertical_line_segment_filter.sv
// A result follows every input transaction; a rejected segment skips the cell walk.
// One segment at a time: a new one is taken only once the last result is in the output register.
// A finished result waits in the output register while the next segment is taken.
// Reset is synchronous: it empties the store, clears the handshakes and loads register defaults.
// The stored lines themselves are not cleared; the line count alone marks them.
module vertical_line_segment_filter import vlsf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [47:0]       s_tdata,  // start_x, start_y, end_x, end_y
  input  logic              s_tuser,  // frame_start
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [39:0]       m_tdata,  // kept, angle, intercept, list_full, zero pad
  input  logic              cfg_we,
  input  logic [ADDR_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]  cfg_wdata
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PREP  = 3'd1;
  localparam logic [2:0] ST_ITER  = 3'd2;
  localparam logic [2:0] ST_FINAL = 3'd3;
  localparam logic [2:0] ST_WALK  = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  logic [2:0]              state;
  logic [WID_W-1:0]        image_width;
  thr_t                    thr;
  logic [CNT_W-1:0]        count;
  logic [COORD_W-1:0]      x0, y0, x1, adx, ady;
  logic                    dx_neg, dy_neg;
  logic [2*COORD_W-1:0]    prod;
  logic [DIV_CNT_W:0]      iter;
  logic                    unit_start;
  logic [ANG_W-1:0]        cordic_angle;
  logic [DIVIDEND_W-1:0]   quotient;
  logic [ANG_W-1:0]        angle;
  logic signed [ICP_W-1:0] icp;
  logic                    kept, full;
  logic signed [31:0]      icp_raw;
  logic signed [31:0]      qs;
  logic [ANG_W-1:0]        ang_now;
  logic signed [ICP_W-1:0] icp_now;
  logic                    pass_now;
  logic [MAG_W-1:0]        mag;
  logic                    head_valid;
  tok_t                    tok_head;
  tok_t                    tok_chain [MAX_LINES];
  ent_t                    ent_chain [MAX_LINES];
  logic                    shift_en;

  assign s_tready = (state == ST_IDLE);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= WIDTH_RST;
      thr.ang_thr <= ATH_RST;
      thr.icp_thr <= ITH_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_IMAGE_WIDTH: image_width <= cfg_wdata[WID_W-1:0];
        REG_ANGLE_THR:   thr.ang_thr <= cfg_wdata[ATH_W-1:0];
        REG_ICP_THR:     thr.icp_thr <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Arithmetic units.
  vlsf_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (unit_start),
    .adx   (adx),
    .ady   (ady),
    .angle (cordic_angle)
  );

  vlsf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (unit_start),
    .dividend (DIVIDEND_W'({prod, 5'd0}) + DIVIDEND_W'(ady)),
    .divisor  ({ady, 1'b0}),
    .quotient (quotient)
  );

  assign unit_start = (state == ST_PREP);

  // Final angle, intercept and pass test.
  always_comb begin
    if (adx == '0) begin
      ang_now = ANGLE_90;
    end else if (ady == '0) begin
      ang_now = '0;
    end else begin
      ang_now = cordic_angle;
    end
    qs      = (dx_neg ^ dy_neg) ? -signed'({2'b0, quotient}) : signed'({2'b0, quotient});
    icp_raw = signed'({16'd0, x0, 4'd0}) - qs;
    if (adx == '0) begin
      icp_now = signed'({1'b0, x0, 4'd0});
    end else if (ady == '0) begin
      if (y0 == '0) begin
        icp_now = signed'({1'b0, x0, 4'd0});
      end else begin
        icp_now = dx_neg ? ICP_W'(SAT_HI) : ICP_W'(SAT_LO);
      end
    end else if (icp_raw > SAT_HI) begin
      icp_now = ICP_W'(SAT_HI);
    end else if (icp_raw < SAT_LO) begin
      icp_now = ICP_W'(SAT_LO);
    end else begin
      icp_now = icp_raw[ICP_W-1:0];
    end
    pass_now = (ang_now > ANGLE_LO) &&
               ((({2'b0, x0} > BORDER) && ({2'b0, x0} + BORDER < {1'b0, image_width})) ||
                (({2'b0, x1} > BORDER) && ({2'b0, x1} + BORDER < {1'b0, image_width})));
  end

  assign mag = icp[ICP_W-1] ? MAG_W'(-icp) : MAG_W'(icp);

  // Sequencer for one segment.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      head_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      head_valid <= (state == ST_FINAL) && pass_now;
      if ((state == ST_OUT) && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            x0     <= s_tdata[11:0];
            y0     <= s_tdata[23:12];
            x1     <= s_tdata[35:24];
            dx_neg <= s_tdata[35:24] < s_tdata[11:0];
            dy_neg <= s_tdata[47:36] < s_tdata[23:12];
            adx    <= (s_tdata[35:24] < s_tdata[11:0]) ? s_tdata[11:0] - s_tdata[35:24]
                                                       : s_tdata[35:24] - s_tdata[11:0];
            ady    <= (s_tdata[47:36] < s_tdata[23:12]) ? s_tdata[23:12] - s_tdata[47:36]
                                                        : s_tdata[47:36] - s_tdata[23:12];
            if (s_tuser) begin
              count <= '0;
            end
            state <= ST_PREP;
          end
        end
        ST_PREP: begin
          iter  <= '0;
          state <= ST_ITER;
        end
        ST_ITER: begin
          iter <= iter + 1'b1;
          if (iter == (DIV_CNT_W + 1)'(DIVIDEND_W)) begin
            state <= ST_FINAL;
          end
        end
        ST_FINAL: begin
          angle <= ang_now;
          icp   <= icp_now;
          kept  <= 1'b0;
          full  <= 1'b0;
          if (pass_now) begin
            state <= ST_WALK;
          end else begin
            state <= ST_OUT;
          end
        end
        ST_WALK: begin
          if (tok_chain[MAX_LINES-1].valid) begin
            if (!tok_chain[MAX_LINES-1].dup) begin
              if (count < CNT_W'(MAX_LINES)) begin
                count <= count + 1'b1;
                kept  <= 1'b1;
              end else begin
                full <= 1'b1;
              end
            end
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tdata <= {6'd0, full, icp, angle, kept};
            state   <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Product ahead of the divider.
  assign prod = y0 * adx;

  // Candidate entering the cell row.
  always_comb begin
    tok_head.valid = head_valid;
    tok_head.rem   = count;
    tok_head.dup   = 1'b0;
    tok_head.angle = angle;
    tok_head.mag   = mag;
  end

  assign shift_en = (state == ST_WALK) && tok_chain[MAX_LINES-1].valid &&
                    !tok_chain[MAX_LINES-1].dup && (count < CNT_W'(MAX_LINES));

  // Row of store cells.
  for (genvar i = 0; i < MAX_LINES; i++) begin : g_cell
    vlsf_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .thr      (thr),
      .tok_in   ((i == 0) ? tok_head : tok_chain[(i == 0) ? 0 : i - 1]),
      .tok_out  (tok_chain[i]),
      .shift_en (shift_en),
      .ent_in   ((i == 0) ? ent_t'({angle, mag}) : ent_chain[(i == 0) ? 0 : i - 1]),
      .ent      (ent_chain[i])
    );
  end

endmodule

// File: rtl/vlsf_checker.sv
// Port-level checks of the vertical line segment filter, bound to the top level.
module vlsf_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata
);

  // One segment at a time: the input closes after a transaction.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while a segment is in work");

  // A stored line never also reports a full store.
  a_kept_not_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && m_tdata[33]))
    else $error("kept and list_full both set");

  // Only near-vertical segments are kept.
  a_kept_angle: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> m_tdata[15:1] > 15'd20480)
    else $error("kept segment outside the angle window");

  // A stalled result stays offered.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result dropped while stalled");

endmodule

bind vertical_line_segment_filter vlsf_checker u_vlsf_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// File: tb/tb.sv
// Testbench of the vertical line segment filter: directed table, a store fill, then random segments.
module tb;
  import vlsf_pkg::*;

  // Named codes used by the stimulus.
  typedef enum logic [1:0] {CHK_PRED = 2'd0, CHK_FIXED = 2'd1} chk_kind_t;
  localparam logic [ADDR_W-1:0] REG_UNUSED = 2'd3;

  // One segment as it enters and one result as it leaves.
  typedef struct packed {
    logic [COORD_W-1:0] x0, y0, x1, y1;
    logic               fs;
  } seg_t;

  typedef struct packed {
    logic               kept;
    logic [ANG_W-1:0]   angle;
    logic [ICP_W-1:0]   icp;
    logic               full;
  } verdict_t;

  typedef struct {
    seg_t      seg;
    chk_kind_t kind;
    verdict_t  fixed;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [47:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic cfg_we = 1'b0;
  logic [ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  always #5 clk = ~clk;

  vertical_line_segment_filter u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  // Shadow of the registers and the line store.
  int unsigned img_w, ang_thr, icp_thr;
  int          line_ang [MAX_LINES];
  int          line_icp [MAX_LINES];
  int unsigned line_cnt;

  verdict_t pending_verdicts[$];
  row_t     rows[$];
  int  errors = 0;
  int  n_kept = 0, n_full = 0, n_seen = 0;
  bit  quiet = 1'b0;
  bit  sending_done = 1'b0;

  // Angle by an 18-step vectoring rotation, in 1/256 degree.
  function automatic int seg_angle(int dx, int dy);
    longint ax, ay, az, xs, ys;
    longint tab [CORDIC_STEPS] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
                                   58666, 29335, 14668, 7334, 3667, 1833, 917, 458,
                                   229, 115, 57, 29};
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    if (dx == 0) return 23040;
    if (dy == 0) return 0;
    ax = longint'(dx) * 65536;
    ay = longint'(dy) * 65536;
    az = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = (ax < 0) ? -((-ax) >>> i) : (ax >>> i);
      ys = (ay < 0) ? -((-ay) >>> i) : (ay >>> i);
      if (ay >= 0) begin
        ax += ys; ay -= xs; az += tab[i];
      end else begin
        ax -= ys; ay += xs; az -= tab[i];
      end
    end
    if (az < 0) return 0;
    az = (az + 128) / 256;
    if (az > 23040) az = 23040;
    return int'(az);
  endfunction

  // Row-0 crossing in 1/16 px, rounded half away from zero and saturated.
  function automatic int seg_icp(int x0, int y0, int dx, int dy);
    longint num, den, q, r;
    bit neg;
    if (dx == 0) return x0 * 16;
    if (dy == 0) return (y0 == 0) ? x0 * 16 : (dx > 0 ? -65536 : 65535);
    num = longint'(16) * y0 * dx;
    den = dy;
    neg = (num < 0) != (den < 0);
    if (num < 0) num = -num;
    if (den < 0) den = -den;
    q = (2 * num + den) / (2 * den);
    if (neg) q = -q;
    r = longint'(x0) * 16 - q;
    if (r > 65535) r = 65535;
    if (r < -65536) r = -65536;
    return int'(r);
  endfunction

  function automatic bit off_border(int x);
    return x > 10 && x < int'(img_w) - 10;
  endfunction

  function automatic int iabs(int v);
    return v < 0 ? -v : v;
  endfunction

  // Predicts the verdict of one segment and updates the shadow store.
  function automatic verdict_t filter_segment(seg_t s);
    verdict_t v;
    int dx, dy, a, c;
    bit dup;
    dx = int'(s.x1) - int'(s.x0);
    dy = int'(s.y1) - int'(s.y0);
    if (s.fs) line_cnt = 0;
    a = seg_angle(dx, dy);
    c = seg_icp(int'(s.x0), int'(s.y0), dx, dy);
    v = '0;
    v.angle = a[ANG_W-1:0];
    v.icp = c[ICP_W-1:0];
    if (a > 20480 && a < 25600 && (off_border(s.x0) || off_border(s.x1))) begin
      dup = 1'b0;
      for (int i = 0; i < int'(line_cnt); i++)
        if (iabs(a - line_ang[i]) < int'(ang_thr) &&
            iabs(iabs(c) - iabs(line_icp[i])) < int'(icp_thr))
          dup = 1'b1;
      if (!dup) begin
        if (line_cnt < MAX_LINES) begin
          line_ang[line_cnt] = a;
          line_icp[line_cnt] = c;
          line_cnt++;
          v.kept = 1'b1;
        end else begin
          v.full = 1'b1;
        end
      end
    end
    return v;
  endfunction

  // Writes one register while the block is idle.
  task automatic write_reg(logic [ADDR_W-1:0] idx, int unsigned val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val[CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_IMAGE_WIDTH: img_w = val & 16'h1FFF;
      REG_ANGLE_THR:   ang_thr = val & 16'h7FFF;
      REG_ICP_THR:     icp_thr = val & 16'hFFFF;
      default: ;
    endcase
  endtask

  // Sends one segment as a transaction, with random gaps before it.
  task automatic send_segment(seg_t s, verdict_t fixed, chk_kind_t kind);
    verdict_t p;
    if (!quiet && $urandom_range(3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(17, 1)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {s.y1, s.x1, s.y0, s.x0};
    s_tuser <= s.fs;
    do @(posedge clk); while (!s_tready);
    p = filter_segment(s);
    if (kind == CHK_FIXED && p != fixed) begin
      $error("table row disagrees with prediction: row %h pred %h", fixed, p);
      errors++;
    end
    pending_verdicts.insert(pending_verdicts.size(), p);
  endtask

  // Waits until every expected result has come back, plus the walk time.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  function automatic seg_t mk(int x0, int y0, int x1, int y1, bit fs);
    seg_t s;
    s.x0 = COORD_W'(x0); s.y0 = COORD_W'(y0); s.x1 = COORD_W'(x1); s.y1 = COORD_W'(y1);
    s.fs = fs;
    return s;
  endfunction

  // Appends one row to the stimulus table.
  function automatic void add_row(seg_t s, chk_kind_t k, verdict_t v);
    row_t r;
    r.seg = s;
    r.kind = k;
    r.fixed = v;
    rows.insert(rows.size(), r);
  endfunction

  // Random segment: mostly near-vertical lines, some fully random noise.
  function automatic seg_t rand_segment();
    seg_t s;
    int x0, y0, len, lean;
    if ($urandom_range(9) < 7) begin
      x0 = $urandom_range(int'(img_w) + 20, 0);
      if (x0 > 4095) x0 = 4095;
      len = $urandom_range(4095, 1);
      y0 = $urandom_range(4095 - len, 0);
      lean = $urandom_range(len / 5, 0);
      if ($urandom_range(1)) lean = -lean;
      if (x0 + lean < 0 || x0 + lean > 4095) lean = -lean;
      if (x0 + lean < 0 || x0 + lean > 4095) lean = 0;
      if ($urandom_range(1)) begin
        s = mk(x0 + lean, y0 + len, x0, y0, 1'b0);
      end else begin
        s = mk(x0, y0, x0 + lean, y0 + len, 1'b0);
      end
    end else begin
      s = mk($urandom_range(4095), $urandom_range(4095), $urandom_range(4095),
             $urandom_range(4095), 1'b0);
    end
    s.fs = ($urandom_range(39) == 0);
    return s;
  endfunction

  // Result side: random stalls and field-by-field compare.
  always @(posedge clk) begin
    verdict_t got, want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = {m_tdata[0], m_tdata[15:1], m_tdata[32:16], m_tdata[33]};
        n_seen++;
        if (pending_verdicts.size() == 0) begin
          $error("result with no expectation waiting: %h", got);
          errors++;
        end else begin
          want = pending_verdicts.pop_front();
          if (got.kept != want.kept) begin
            $error("kept: expected %0d actual %0d", want.kept, got.kept); errors++;
          end
          if (got.angle != want.angle) begin
            $error("angle: expected %0d actual %0d", want.angle, got.angle); errors++;
          end
          if (got.icp != want.icp) begin
            $error("intercept: expected %0d actual %0d", $signed(want.icp),
                   $signed(got.icp));
            errors++;
          end
          if (got.full != want.full) begin
            $error("list_full: expected %0d actual %0d", want.full, got.full); errors++;
          end
          n_kept += got.kept;
          n_full += got.full;
        end
      end
      if (quiet) m_tready <= 1'b1;
      else if ($urandom_range(7) == 0) m_tready <= ~m_tready;
      else if (!m_tready && $urandom_range(5) == 0) m_tready <= 1'b1;
    end
  end

  // Watchdog on cycles with no transaction.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 4000) begin
      $display("tb failed");
      $finish;
    end
  end

  // Stimulus.
  initial begin
    verdict_t f;
    seg_t s;
    img_w = 640; ang_thr = 512; icp_thr = 48; line_cnt = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table; fixed rows are read straight off the arithmetic.
    f = '0; f.kept = 1'b1; f.angle = 15'd23040; f.icp = 17'(100 * 16);
    add_row(mk(100, 0, 100, 50, 1), CHK_FIXED, f);
    f.kept = 1'b0;
    add_row(mk(100, 0, 100, 50, 0), CHK_FIXED, f);
    f = '0; f.angle = '0; f.icp = 17'(200 * 16);
    add_row(mk(200, 0, 300, 0, 0), CHK_FIXED, f);
    f = '0; f.angle = '0; f.icp = 17'h10000;
    add_row(mk(10, 5, 20, 5, 0), CHK_FIXED, f);
    f = '0; f.angle = '0; f.icp = 17'h0FFFF;
    add_row(mk(20, 5, 10, 5, 0), CHK_FIXED, f);
    f = '0; f.angle = 15'd23040; f.icp = '0;
    add_row(mk(0, 0, 0, 0, 0), CHK_FIXED, f);
    f = '0; f.angle = 15'd23040; f.icp = 17'(4095 * 16);
    add_row(mk(4095, 4095, 4095, 4095, 0), CHK_FIXED, f);
    f = '0; f.angle = 15'd23040; f.icp = 17'(10 * 16);
    add_row(mk(10, 0, 10, 99, 0), CHK_FIXED, f);
    f.kept = 1'b1; f.icp = 17'(11 * 16);
    add_row(mk(11, 0, 11, 99, 0), CHK_FIXED, f);
    f = '0;
    add_row(mk(0, 0, 4095, 4095, 0), CHK_PRED, f);
    add_row(mk(4095, 0, 0, 4095, 0), CHK_PRED, f);
    add_row(mk(300, 4095, 310, 0, 0), CHK_PRED, f);
    add_row(mk(310, 0, 300, 4095, 0), CHK_PRED, f);
    add_row(mk(4095, 4095, 3000, 0, 0), CHK_PRED, f);
    add_row(mk(0, 4095, 0, 0, 0), CHK_PRED, f);
    add_row(mk(629, 0, 640, 100, 0), CHK_PRED, f);
    add_row(mk(630, 0, 635, 100, 0), CHK_PRED, f);
    add_row(mk(400, 100, 420, 0, 0), CHK_PRED, f);
    add_row(mk(400, 100, 418, 0, 0), CHK_PRED, f);
    add_row(mk(1, 4095, 2, 4094, 1), CHK_PRED, f);
    foreach (rows[i]) send_segment(rows[i].seg, rows[i].fixed, rows[i].kind);
    drain();

    // Zero thresholds: nothing is a duplicate, so the store fills up.
    write_reg(REG_ANGLE_THR, 0);
    write_reg(REG_ICP_THR, 0);
    write_reg(REG_UNUSED, 16'hFFFF);
    for (int i = 0; i < 70; i++) send_segment(mk(100, 0, 100, 10, i == 0), '0, CHK_PRED);
    drain();

    // Random phases over several register settings, extremes among them.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin write_reg(REG_IMAGE_WIDTH, 21); write_reg(REG_ANGLE_THR, 23040);
                 write_reg(REG_ICP_THR, 65535); end
        1: begin write_reg(REG_IMAGE_WIDTH, 4096); write_reg(REG_ANGLE_THR, 512);
                 write_reg(REG_ICP_THR, 48); end
        2: begin write_reg(REG_IMAGE_WIDTH, 640); write_reg(REG_ANGLE_THR, 64);
                 write_reg(REG_ICP_THR, 4); end
        3: begin write_reg(REG_IMAGE_WIDTH, $urandom_range(4096, 21));
                 write_reg(REG_ANGLE_THR, $urandom_range(2000));
                 write_reg(REG_ICP_THR, $urandom_range(600)); end
        default: begin write_reg(REG_IMAGE_WIDTH, 1920); write_reg(REG_ANGLE_THR, 256);
                 write_reg(REG_ICP_THR, 16); quiet = 1'b1; end
      endcase
      for (int i = 0; i < 60; i++) begin
        s = rand_segment();
        if (i == 0) s.fs = 1'b1;
        send_segment(s, '0, CHK_PRED);
      end
      drain();
    end

    $display("Covered %0d results: %0d segments kept, %0d dropped on a full store.",
             n_seen, n_kept, n_full);
    $display("Register settings went through width, angle and intercept extremes.");
    if (errors == 0 && pending_verdicts.size() == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end
endmodule
